// ----- rtl/bounded_ordered_list_engine_top_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the ordered list engine
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef BOUNDED_ORDERED_LIST_ENGINE_TOP_ASSERT_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_TOP_ASSERT_SVH

// condition holds at every edge
`define BOLE_CHECK(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent at the same edge
`define BOLE_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent at the next edge
`define BOLE_IMPLY_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bole_pkg.sv -----
// ---------------------------------------------------------------------------
// bole_pkg
// Action codes and controller command type for the ordered list engine.
// ---------------------------------------------------------------------------
package bole_pkg;

  localparam logic [2:0] ACT_PUSH   = 3'd0;
  localparam logic [2:0] ACT_POP    = 3'd1;
  localparam logic [2:0] ACT_INSERT = 3'd2;
  localparam logic [2:0] ACT_DELETE = 3'd3;
  localparam logic [2:0] ACT_CLEAR  = 3'd4;

  typedef struct packed {
    logic load;     // capture input beat
    logic compare;  // register per-cell compare flags
    logic commit;   // update cells, load result register
  } bole_cmd_t;

endpackage

// ----- rtl/bole_ctrl.sv -----
// ---------------------------------------------------------------------------
// bole_ctrl
// Sequencer: accept, compare, commit; owns both handshakes.
// ---------------------------------------------------------------------------
module bole_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output bole_pkg::bole_cmd_t cmd
);
  import bole_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) || ((state_r == ST_EXEC) && slot_free);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.load    = in_valid && in_ready;
    cmd.compare = (state_r == ST_CMP);
    cmd.commit  = (state_r == ST_EXEC) && slot_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_CMP;
      ST_CMP:  state_nxt = ST_EXEC;
      ST_EXEC: if (slot_free) state_nxt = in_valid ? ST_CMP : ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`include "bounded_ordered_list_engine_top_assert.svh"

  `BOLE_IMPLY_NEXT(a_load_to_cmp, cmd.load, state_r == ST_CMP, "accepted beat not compared")
  `BOLE_IMPLY_NEXT(a_cmp_to_exec, state_r == ST_CMP, state_r == ST_EXEC, "compare not followed by commit stage")
  `BOLE_IMPLY_NEXT(a_commit_shows, cmd.commit, out_valid_r, "commit did not present a result")
  `BOLE_CHECK(a_one_phase, !(cmd.compare && cmd.commit), "compare and commit together")

endmodule

// ----- rtl/bole_dp.sv -----
// ---------------------------------------------------------------------------
// bole_dp
// Row of compare-and-shift cells, entry count and result register.
// ---------------------------------------------------------------------------
module bole_dp #(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bole_pkg::bole_cmd_t cmd,
  input  logic [2:0]          in_action,
  input  logic signed [31:0]  in_value,
  output logic                out_ok,
  output logic [4:0]          out_item_count,
  output logic                out_list_empty,
  output logic                out_front_valid,
  output logic signed [31:0]  out_front_value
);
  import bole_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [2:0]         act_r;
  logic signed [31:0] val_r;
  logic signed [31:0] ent_r   [DEPTH];
  logic signed [31:0] ent_nxt [DEPTH];
  logic [CW-1:0]      cnt_r, cnt_nxt;

  logic [DEPTH-1:0] gt_r, stop_r, eq_r;   // insert stop, delete stop, equality
  logic [DEPTH-1:0] live, flag, past_stop, first;
  logic             full, found, ok_nxt;
  logic             do_push, do_ins, do_pop, do_del;

  logic             ok_r;
  logic [4:0]       count_out_r;
  logic             empty_r, fvalid_r;
  logic signed [31:0] front_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_action;
      val_r <= in_value;
    end
  end

  // compare stage
  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      for (int i = 0; i < DEPTH; i++) begin
        gt_r[i]   <= !live[i] || (val_r < ent_r[i]);
        stop_r[i] <= !live[i] || !(ent_r[i] < val_r);
        eq_r[i]   <= ent_r[i] == val_r;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) live[i] = CW'(i) < cnt_r;
    flag = (act_r == ACT_INSERT) ? gt_r : stop_r;
    past_stop[0] = 1'b0;
    for (int i = 1; i < DEPTH; i++) past_stop[i] = past_stop[i-1] | flag[i-1];
    first = flag & ~past_stop;
    found = |(first & eq_r & live);
    full  = cnt_r == CW'(DEPTH);
  end

  always_comb begin
    do_push = 1'b0;
    do_ins  = 1'b0;
    do_pop  = 1'b0;
    do_del  = 1'b0;
    ok_nxt  = 1'b0;
    cnt_nxt = cnt_r;
    unique case (act_r)
      ACT_PUSH: begin
        do_push = !full;
        ok_nxt  = !full;
        if (!full) cnt_nxt = cnt_r + CW'(1);
      end
      ACT_POP: begin
        do_pop = cnt_r != '0;
        ok_nxt = cnt_r != '0;
        if (cnt_r != '0) cnt_nxt = cnt_r - CW'(1);
      end
      ACT_INSERT: begin
        do_ins = !full;
        ok_nxt = !full;
        if (!full) cnt_nxt = cnt_r + CW'(1);
      end
      ACT_DELETE: begin
        do_del = found;
        ok_nxt = found;
        if (found) cnt_nxt = cnt_r - CW'(1);
      end
      ACT_CLEAR: begin
        ok_nxt  = 1'b1;
        cnt_nxt = '0;
      end
      default: ;
    endcase
  end

  // per-cell next value
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [31:0] prev_v, next_v;
    if (g == 0) begin : g_head
      assign prev_v = val_r;
    end else begin : g_body
      assign prev_v = ent_r[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign next_v = ent_r[g];
    end else begin : g_inner
      assign next_v = ent_r[g+1];
    end
    always_comb begin
      ent_nxt[g] = ent_r[g];
      priority if (do_push) begin
        ent_nxt[g] = prev_v;
      end else if (do_ins && first[g]) begin
        ent_nxt[g] = val_r;
      end else if (do_ins && past_stop[g]) begin
        ent_nxt[g] = prev_v;
      end else if (do_pop || (do_del && (past_stop[g] || first[g]))) begin
        ent_nxt[g] = next_v;
      end else begin
        ent_nxt[g] = ent_r[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int i = 0; i < DEPTH; i++) ent_r[i] <= ent_nxt[i];
      ok_r        <= ok_nxt;
      count_out_r <= 5'(cnt_nxt);
      empty_r     <= cnt_nxt == '0;
      fvalid_r    <= cnt_nxt != '0;
      front_r     <= (cnt_nxt != '0) ? ent_nxt[0] : 32'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else if (cmd.commit) cnt_r <= cnt_nxt;
  end

  assign out_ok          = ok_r;
  assign out_item_count  = count_out_r;
  assign out_list_empty  = empty_r;
  assign out_front_valid = fvalid_r;
  assign out_front_value = front_r;

`include "bounded_ordered_list_engine_top_assert.svh"

  `BOLE_CHECK(a_cnt_bound, cnt_r <= CW'(DEPTH), "entry count above depth")
  `BOLE_IMPLY_NEXT(a_clear_empties, cmd.commit && act_r == ACT_CLEAR, cnt_r == '0, "clear left entries")
  `BOLE_IMPLY_NEXT(a_push_front, cmd.commit && act_r == ACT_PUSH && !full, ent_r[0] == $past(val_r), "push not at front")

endmodule

// ----- rtl/bounded_ordered_list_engine_top.sv -----
// ---------------------------------------------------------------------------
// bounded_ordered_list_engine_top
// Ordered list of up to DEPTH signed words with push, pop, insert, delete, clear.
// ---------------------------------------------------------------------------
// Input channel in_valid/in_ready carries one beat: in_action and in_value.
// Output channel out_valid/out_ready returns one beat per input beat: ok
// flag, entry count (low 5 bits), empty flag and front entry after the
// action.
// Each beat passes through the compare stage, where every cell compares
// its entry with the operand, and then the commit stage, where the cells
// shift and the result register is loaded. A new beat is taken in the
// commit cycle of the previous one, at any depth.
// The result register separates the channels: a beat may be accepted and
// compared while the previous result waits; commit holds while out_ready is
// low and the result register is still full.
// Reset empties the list at once; entry storage is left as is.
// ---------------------------------------------------------------------------
module bounded_ordered_list_engine_top #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_action,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_ok,
  output logic [4:0]         out_item_count,
  output logic               out_list_empty,
  output logic               out_front_valid,
  output logic signed [31:0] out_front_value
);
  import bole_pkg::*;

  bole_cmd_t cmd;

  bole_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  bole_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_action       (in_action),
    .in_value        (in_value),
    .out_ok          (out_ok),
    .out_item_count  (out_item_count),
    .out_list_empty  (out_list_empty),
    .out_front_valid (out_front_valid),
    .out_front_value (out_front_value)
  );

endmodule
